// ===== rtl/core/asp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the atlas shelf packer.
// Page count, coordinate widths, register indexes, action and status codes.
// No dependencies.
package asp_pkg;

  // Page store and coordinate sizing.
  localparam int MAX_PAGES  = 8;
  localparam int COORD_BITS = 13;
  localparam int PAGE_BITS  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int FMT_BITS   = 4;
  localparam int STATUS_BITS = 2;

  localparam logic [PAGE_BITS-1:0] LAST_PAGE = PAGE_BITS'(MAX_PAGES - 1);

  // Register reset values.
  localparam logic [COORD_BITS-1:0] PAGE_SIZE_RESET = COORD_BITS'(512);

  // Configuration register indexes.
  localparam logic REG_PAGE_WIDTH  = 1'b0;
  localparam logic REG_PAGE_HEIGHT = 1'b1;

  // Input actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NO_PAGE   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_TOO_LARGE = 2'd2;

endpackage

// ===== rtl/core/atlas_shelf_packer.sv =====
`timescale 1ns / 1ps
// Top level of the atlas shelf packer: sequencer, page state and result register.
// Depends on asp_pkg for sizes and codes.

// An allocate or clear item is taken when the block is idle. Its result
// appears on the output register after a walk of variable length: a size
// check, then a scan that visits the pages in order, then a step that places
// the rectangle and updates the chosen page. The scan stops at the first page
// that fits, or it runs through all MAX_PAGES pages (eight here). A request
// that finds no free page also runs through all pages. A clear or a
// too-large request goes from the size check straight to its result. The
// block returns to idle before it takes the next item. The scan visits one
// page per cycle through a single shared fit unit (three adds and three
// compares). A new item is accepted while the previous result still waits
// on a stalled output; the block holds its final step until the output
// register is free.
module atlas_shelf_packer (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [asp_pkg::COORD_BITS-1:0]       rect_width,
  input  logic [asp_pkg::COORD_BITS-1:0]       rect_height,
  input  logic [asp_pkg::FMT_BITS-1:0]         pixel_format,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [asp_pkg::PAGE_BITS-1:0]        page_index,
  output logic [asp_pkg::COORD_BITS-1:0]       x_pos,
  output logic [asp_pkg::COORD_BITS-1:0]       y_pos,
  output logic                                 opened_page,
  output logic [asp_pkg::STATUS_BITS-1:0]      status,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [asp_pkg::COORD_BITS-1:0]       cfg_data
);

  localparam int CB = asp_pkg::COORD_BITS;
  localparam int PB = asp_pkg::PAGE_BITS;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  localparam logic [CB-1:0] ONE = CB'(1);

  logic [2:0] state;

  // Configuration registers.
  logic [CB-1:0] page_width;
  logic [CB-1:0] page_height;

  // Page state.
  logic [asp_pkg::MAX_PAGES-1:0] page_open;
  logic [asp_pkg::FMT_BITS-1:0]  page_format  [asp_pkg::MAX_PAGES];
  logic [CB-1:0]                 cursor_x     [asp_pkg::MAX_PAGES];
  logic [CB-1:0]                 cursor_y     [asp_pkg::MAX_PAGES];
  logic [CB-1:0]                 shelf_height [asp_pkg::MAX_PAGES];

  // Latched item and scan bookkeeping.
  logic                          item_action;
  logic [CB-1:0]                 item_w;
  logic [CB-1:0]                 item_h;
  logic [asp_pkg::FMT_BITS-1:0]  item_fmt;
  logic [PB-1:0]                 idx;
  logic                          free_found;
  logic [PB-1:0]                 free_idx;
  logic                          opening;
  logic [asp_pkg::STATUS_BITS-1:0] report_status;

  logic out_free;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Too-large test on the latched item.
  logic too_large;
  assign too_large = (({1'b0, item_w} + (CB+1)'(1)) > {1'b0, page_width}) ||
                     (({1'b0, item_h} + (CB+1)'(1)) > {1'b0, page_height});

  // Shared fit unit: reads the page at idx, or a fresh page while opening.
  logic [CB-1:0] base_cx, base_cy, base_sh;
  logic [CB:0]   sum_x;
  logic [CB+1:0] sum_y_cur, sum_y_new;
  logic          on_shelf, page_fit, page_hit;

  always_comb begin
    base_cx = opening ? ONE : cursor_x[idx];
    base_cy = opening ? ONE : cursor_y[idx];
    base_sh = opening ? '0  : shelf_height[idx];
    sum_x     = {1'b0, base_cx} + {1'b0, item_w};
    sum_y_cur = {2'b00, base_cy} + {2'b00, item_h};
    sum_y_new = sum_y_cur + {2'b00, base_sh};
    on_shelf  = (sum_x <= {1'b0, page_width});
    page_fit  = on_shelf ? (sum_y_cur <= {2'b00, page_height})
                         : (sum_y_new <= {2'b00, page_height});
    page_hit  = page_open[idx] && (page_format[idx] == item_fmt) && page_fit;
  end

  // Placement of the rectangle on the chosen page.
  logic [CB-1:0] place_x, place_y, place_sh_base, new_sh, new_cx;
  always_comb begin
    place_x       = on_shelf ? base_cx : ONE;
    place_y       = on_shelf ? base_cy : CB'(base_cy + base_sh);
    place_sh_base = on_shelf ? base_sh : '0;
    new_sh        = (item_h > place_sh_base) ? item_h : place_sh_base;
    new_cx        = CB'(place_x + item_w);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_width  <= asp_pkg::PAGE_SIZE_RESET;
      page_height <= asp_pkg::PAGE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        asp_pkg::REG_PAGE_WIDTH:  page_width  <= cfg_data;
        asp_pkg::REG_PAGE_HEIGHT: page_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_action <= action;
      item_w      <= rect_width;
      item_h      <= rect_height;
      item_fmt    <= pixel_format;
    end
  end

  // Page store updates; only the open flags carry a reset.
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && out_free) begin
      page_format[idx]  <= item_fmt;
      cursor_x[idx]     <= new_cx;
      cursor_y[idx]     <= place_y;
      shelf_height[idx] <= new_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_open <= '0;
    end else if (state == ST_UPDATE && out_free) begin
      page_open[idx] <= 1'b1;
    end else if (state == ST_REPORT && out_free && item_action == asp_pkg::ACT_CLEAR) begin
      page_open <= '0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      opening    <= 1'b0;
      report_status <= asp_pkg::STATUS_OK;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          idx        <= '0;
          free_found <= 1'b0;
          opening    <= 1'b0;
          if (item_action == asp_pkg::ACT_CLEAR) begin
            report_status <= asp_pkg::STATUS_OK;
            state         <= ST_REPORT;
          end else if (too_large) begin
            report_status <= asp_pkg::STATUS_TOO_LARGE;
            state         <= ST_REPORT;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!page_open[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (page_hit) begin
            state <= ST_UPDATE;
          end else if (idx == asp_pkg::LAST_PAGE) begin
            if (free_found) begin
              idx     <= free_idx;
              opening <= 1'b1;
              state   <= ST_UPDATE;
            end else if (!page_open[idx]) begin
              opening <= 1'b1;
              state   <= ST_UPDATE;
            end else begin
              report_status <= asp_pkg::STATUS_NO_PAGE;
              state         <= ST_REPORT;
            end
          end else begin
            idx <= idx + PB'(1);
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_UPDATE && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ST_REPORT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && out_free) begin
      page_index  <= idx;
      x_pos       <= place_x;
      y_pos       <= place_y;
      opened_page <= opening;
      status      <= asp_pkg::STATUS_OK;
    end else if (state == ST_REPORT && out_free) begin
      page_index  <= '0;
      x_pos       <= '0;
      y_pos       <= '0;
      opened_page <= 1'b0;
      status      <= report_status;
    end
  end

  // Error and clear results carry no placement.
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != asp_pkg::STATUS_OK) |->
      (x_pos == '0 && y_pos == '0 && !opened_page && page_index == '0))
    else $error("error result carries a placement");

  // A freshly opened page always places at its first corner.
  a_open_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && opened_page) |-> (x_pos == ONE && y_pos == ONE))
    else $error("opened page did not place at its first corner");

  // An accepted item always starts with the size check.
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_CHECK))
    else $error("accepted item did not start the size check");

  // A placement marks its page open.
  a_update_open: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && out_free) |=> page_open[$past(idx)])
    else $error("placed page not marked open");

endmodule

// ===== tb/sv/atlas_shelf_packer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for atlas_shelf_packer: directed and random rectangle requests
// under several page sizes, checked against an in-bench shelf placement predictor.
// Depends on asp_pkg and the atlas_shelf_packer RTL.
module atlas_shelf_packer_tb;

  localparam int RUN_LIMIT    = 600000;
  localparam int PHASE_ITEMS  = 125;
  localparam int TAIL_CYCLES  = 30;
  localparam int MAX_REPORTED = 50;

  typedef struct packed {
    logic                           act;
    logic [asp_pkg::COORD_BITS-1:0] w;
    logic [asp_pkg::COORD_BITS-1:0] h;
    logic [asp_pkg::FMT_BITS-1:0]   fmt;
  } rect_req_t;

  typedef struct packed {
    logic [asp_pkg::PAGE_BITS-1:0]   page;
    logic [asp_pkg::COORD_BITS-1:0]  x;
    logic [asp_pkg::COORD_BITS-1:0]  y;
    logic                            opened;
    logic [asp_pkg::STATUS_BITS-1:0] code;
  } placement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            action = asp_pkg::ACT_ALLOC;
  logic [asp_pkg::COORD_BITS-1:0]  rect_width = '0;
  logic [asp_pkg::COORD_BITS-1:0]  rect_height = '0;
  logic [asp_pkg::FMT_BITS-1:0]    pixel_format = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [asp_pkg::PAGE_BITS-1:0]   page_index;
  logic [asp_pkg::COORD_BITS-1:0]  x_pos;
  logic [asp_pkg::COORD_BITS-1:0]  y_pos;
  logic                            opened_page;
  logic [asp_pkg::STATUS_BITS-1:0] status;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = asp_pkg::REG_PAGE_WIDTH;
  logic [asp_pkg::COORD_BITS-1:0]  cfg_data = '0;

  atlas_shelf_packer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .pixel_format (pixel_format),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .page_index   (page_index),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .opened_page  (opened_page),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Requests waiting to be driven and placements waiting to come back.
  rect_req_t  rect_queue[$];
  placement_t placement_q[$];
  int rects_queued = 0;
  int rects_taken = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  logic steady;

  // Predictor copy of the page table and the page size registers.
  logic                          pg_open  [asp_pkg::MAX_PAGES];
  logic [asp_pkg::FMT_BITS-1:0]  pg_fmt   [asp_pkg::MAX_PAGES];
  int unsigned                   pg_cx    [asp_pkg::MAX_PAGES];
  int unsigned                   pg_cy    [asp_pkg::MAX_PAGES];
  int unsigned                   pg_shelf [asp_pkg::MAX_PAGES];
  int unsigned                   atlas_w;
  int unsigned                   atlas_h;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stretches with no idling on either side recur periodically.
  assign steady = (cycle_cnt % 5000) < 700;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, int got, int want_val);
    if (err_cnt < MAX_REPORTED)
      $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want_val);
    err_cnt++;
  endtask

  // Shelf placement of one request against the predictor's page table.
  function automatic placement_t shelf_place(logic act, int unsigned w, int unsigned h,
                                             logic [asp_pkg::FMT_BITS-1:0] fmt);
    placement_t  r;
    int          pick;
    int unsigned px;
    int unsigned py;
    r = '0;
    pick = -1;
    if (act == asp_pkg::ACT_CLEAR) begin
      for (int i = 0; i < asp_pkg::MAX_PAGES; i++) pg_open[i] = 1'b0;
      return r;
    end
    if (1 + w > atlas_w || 1 + h > atlas_h) begin
      r.code = asp_pkg::STATUS_TOO_LARGE;
      return r;
    end
    // First open page of this format with room on the shelf or below it.
    for (int i = 0; i < asp_pkg::MAX_PAGES && pick < 0; i++) begin
      if (pg_open[i] && pg_fmt[i] == fmt) begin
        if (pg_cx[i] + w <= atlas_w) begin
          if (pg_cy[i] + h <= atlas_h) pick = i;
        end else if (pg_cy[i] + pg_shelf[i] + h <= atlas_h) begin
          pick = i;
        end
      end
    end
    // Otherwise open the lowest free page.
    if (pick < 0) begin
      for (int i = 0; i < asp_pkg::MAX_PAGES && pick < 0; i++)
        if (!pg_open[i]) pick = i;
      if (pick < 0) begin
        r.code = asp_pkg::STATUS_NO_PAGE;
        return r;
      end
      pg_open[pick]  = 1'b1;
      pg_fmt[pick]   = fmt;
      pg_cx[pick]    = 1;
      pg_cy[pick]    = 1;
      pg_shelf[pick] = 0;
      r.opened       = 1'b1;
    end
    if (pg_cx[pick] + w > atlas_w) begin
      pg_cx[pick]    = 1;
      pg_cy[pick]    = (pg_cy[pick] + pg_shelf[pick]) % (1 << asp_pkg::COORD_BITS);
      pg_shelf[pick] = 0;
    end
    px = pg_cx[pick];
    py = pg_cy[pick];
    if (h > pg_shelf[pick]) pg_shelf[pick] = h % (1 << asp_pkg::COORD_BITS);
    pg_cx[pick] = (pg_cx[pick] + w) % (1 << asp_pkg::COORD_BITS);
    r.page = asp_pkg::PAGE_BITS'(pick);
    r.x    = asp_pkg::COORD_BITS'(px);
    r.y    = asp_pkg::COORD_BITS'(py);
    r.code = asp_pkg::STATUS_OK;
    return r;
  endfunction

  // Request driver: holds each request until its transfer, then may idle.
  always @(posedge clk) begin : rect_driver
    rect_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        placement_q = {placement_q,
                       shelf_place(action, rect_width, rect_height, pixel_format)};
        rects_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (rect_queue.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
          nxt = rect_queue.pop_front();
          action       <= nxt.act;
          rect_width   <= nxt.w;
          rect_height  <= nxt.h;
          pixel_format <= nxt.fmt;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random output stalls, field by field check of each transfer.
  always @(posedge clk) begin : result_check
    placement_t want;
    out_stall <= !steady && ($urandom_range(99) < 29);
    if (!rst && out_valid && !out_stall) begin
      if (placement_q.size() == 0) begin
        flag_mismatch("unexpected result, status", status, -1);
      end else begin
        want = placement_q.pop_front();
        if (page_index !== want.page) flag_mismatch("page_index", page_index, want.page);
        if (x_pos !== want.x) flag_mismatch("x_pos", x_pos, want.x);
        if (y_pos !== want.y) flag_mismatch("y_pos", y_pos, want.y);
        if (opened_page !== want.opened) flag_mismatch("opened_page", opened_page, want.opened);
        if (status !== want.code) flag_mismatch("status", status, want.code);
      end
    end
  end

  task automatic queue_rect(logic act, int unsigned w, int unsigned h, int unsigned fmt);
    rect_req_t req;
    req = '{act: act, w: asp_pkg::COORD_BITS'(w), h: asp_pkg::COORD_BITS'(h),
            fmt: asp_pkg::FMT_BITS'(fmt)};
    rect_queue = {rect_queue, req};
    rects_queued++;
  endtask

  // Mostly small rectangles so shelves and pages fill, sometimes up to the page size.
  function automatic int unsigned pick_span(int unsigned lim);
    if ($urandom_range(4) == 0) return $urandom_range(lim - 1);
    return $urandom_range((lim - 1) / 4);
  endfunction

  task automatic queue_random_rects(int n, int unsigned pw, int unsigned ph);
    int          roll;
    int unsigned w;
    int unsigned h;
    int unsigned fmt;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      fmt = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
      w = pick_span(pw);
      h = pick_span(ph);
      if (roll < 3) begin
        queue_rect(asp_pkg::ACT_CLEAR, $urandom_range(4096), $urandom_range(4096), fmt);
      end else if (roll < 9) begin
        // One side too large for any page.
        if (roll[0]) w = $urandom_range(4096, pw);
        else h = $urandom_range(4096, ph);
        queue_rect(asp_pkg::ACT_ALLOC, w, h, fmt);
      end else begin
        queue_rect(asp_pkg::ACT_ALLOC, w, h, fmt);
      end
    end
  endtask

  // Waits until every queued request has made its transfer and its result came back.
  task automatic wait_drained();
    do @(posedge clk);
    while (rects_taken != rects_queued || placement_q.size() != 0);
  endtask

  task automatic write_page_reg(logic idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= asp_pkg::COORD_BITS'(val);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == asp_pkg::REG_PAGE_WIDTH) atlas_w = val;
    else atlas_h = val;
  endtask

  // Stimulus sequence: directed checks at the reset page size, then random phases.
  initial begin : stimulus
    int unsigned pw_list[12];
    int unsigned ph_list[12];
    atlas_w = asp_pkg::PAGE_SIZE_RESET;
    atlas_h = asp_pkg::PAGE_SIZE_RESET;
    for (int i = 0; i < asp_pkg::MAX_PAGES; i++) begin
      pg_open[i]  = 1'b0;
      pg_fmt[i]   = '0;
      pg_cx[i]    = 0;
      pg_cy[i]    = 0;
      pg_shelf[i] = 0;
    end
    pw_list = '{512, 64, 4096, 1, 4096, 3, 200, 16, 4095, 1000, 0, 0};
    ph_list = '{512, 48, 4096, 1, 1, 4096, 333, 16, 1365, 77, 0, 0};
    pw_list[10] = $urandom_range(1, 4096);
    ph_list[10] = $urandom_range(1, 4096);
    pw_list[11] = $urandom_range(1, 64);
    ph_list[11] = $urandom_range(1, 64);

    // Zero size, widest fit, too large in each dimension, shelf and page overflow.
    queue_rect(asp_pkg::ACT_ALLOC, 0, 0, 0);
    queue_rect(asp_pkg::ACT_ALLOC, 511, 10, 0);
    queue_rect(asp_pkg::ACT_ALLOC, 512, 1, 0);
    queue_rect(asp_pkg::ACT_ALLOC, 1, 512, 0);
    queue_rect(asp_pkg::ACT_ALLOC, 4096, 4096, 15);
    queue_rect(asp_pkg::ACT_ALLOC, 100, 511, 15);
    queue_rect(asp_pkg::ACT_ALLOC, 10, 20, 0);
    queue_rect(asp_pkg::ACT_ALLOC, 0, 0, 15);
    queue_rect(asp_pkg::ACT_ALLOC, 411, 1, 15);
    queue_rect(asp_pkg::ACT_ALLOC, 1, 1, 15);
    // Fill the remaining pages with other formats, then run out of pages.
    for (int f = 2; f <= 6; f++) queue_rect(asp_pkg::ACT_ALLOC, 255, 255, f);
    queue_rect(asp_pkg::ACT_ALLOC, 8, 8, 8);
    queue_rect(asp_pkg::ACT_ALLOC, 511, 511, 0);
    queue_rect(asp_pkg::ACT_CLEAR, 0, 0, 0);
    queue_rect(asp_pkg::ACT_ALLOC, 7, 9, 10);
    queue_rect(asp_pkg::ACT_ALLOC, 13, 1, 5);
    queue_rect(asp_pkg::ACT_CLEAR, 4096, 4096, 15);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // Pages stay open across some size changes; the fit uses the new sizes.
    for (int p = 0; p < 12; p++) begin
      write_page_reg(asp_pkg::REG_PAGE_WIDTH, pw_list[p]);
      write_page_reg(asp_pkg::REG_PAGE_HEIGHT, ph_list[p]);
      queue_random_rects(PHASE_ITEMS, pw_list[p], ph_list[p]);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (placement_q.size() != 0)
      flag_mismatch("results never returned", 0, placement_q.size());
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
